// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL that carries inline checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mhla_pkg.sv -----
// Shared constants, register indexes and interface types of the hinge loss accumulator.
package mhla_pkg;

  localparam int SCORE_W     = 16;
  localparam int MARGIN_W    = 15;
  localparam int GRAD_W      = 32;
  localparam int LOSS_W      = 31;
  localparam int SUM_W       = 48;
  localparam int CLASS_W     = 10;
  localparam int CFG_W       = 16;
  localparam int MAX_CLASSES = 1024;

  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = 1;

  // Divider: gradient dividend and batch loss dividend widths
  localparam int GDIV_W      = 34;
  localparam int DIV_W       = 56;
  localparam int DIVCNT_W    = 6;

  localparam logic signed [SCORE_W+1:0] ONE_Q88 = 18'sd256;

  typedef enum logic [1:0] {
    REG_CLASS_MODE   = 2'd0,
    REG_NORM_SELECT  = 2'd1,
    REG_SAMPLE_COUNT = 2'd2,
    REG_LOSS_WEIGHT  = 2'd3
  } reg_idx_t;

  // Classified element: clipped margin, sign of the signed margin, end of batch
  typedef struct packed {
    logic [MARGIN_W-1:0] margin;
    logic                neg;
    logic                last;
  } item_t;

  typedef struct packed {
    logic             norm_select;
    logic [CFG_W-1:0] num;
    logic [CFG_W-1:0] up_weight;
  } back_cfg_t;

endpackage

// ----- hw/rtl/mhla_front.sv -----
// Front end: label decode and clipped hinge margin per element.
module mhla_front import mhla_pkg::*; (
  input  logic                      class_mode,
  input  logic signed [SCORE_W-1:0] score,
  input  logic signed [1:0]         label_sign,
  input  logic                      mask_bit,
  input  logic [CLASS_W-1:0]        class_label,
  input  logic [CLASS_W-1:0]        element_index,
  input  logic                      last,
  output item_t                     item
);

  logic signed [SCORE_W+1:0] score_x;
  logic signed [SCORE_W+1:0] val;
  logic                      hit;
  logic                      lab_pos;
  logic                      lab_ok;
  logic                      active;
  logic                      neg_raw;
  logic [MARGIN_W-1:0]       margin;

  always_comb begin
    score_x = {{2{score[SCORE_W-1]}}, score};
    hit     = ({1'b0, class_label} < (CLASS_W+1)'(MAX_CLASSES)) &&
              (element_index == class_label);
    lab_pos = (label_sign == 2'sb01);
    lab_ok  = (label_sign == 2'sb01) || (label_sign == 2'sb11);
    if (class_mode) begin
      val     = hit ? (ONE_Q88 - score_x) : (ONE_Q88 + score_x);
      active  = 1'b1;
      neg_raw = hit;
    end else begin
      val     = lab_pos ? (ONE_Q88 - score_x) : (ONE_Q88 + score_x);
      active  = mask_bit && lab_ok;
      neg_raw = lab_pos;
    end
    if (!active || val < 0) begin
      margin = '0;
    end else if (val > (SCORE_W+2)'(signed'({1'b0, {MARGIN_W{1'b1}}}))) begin
      margin = '1;
    end else begin
      margin = val[MARGIN_W-1:0];
    end
    item.margin = margin;
    item.neg    = active && neg_raw && (margin != '0);
    item.last   = last;
  end

endmodule

// ----- hw/rtl/mhla_fifo.sv -----
// Short queue of classified elements between front and back end.
module mhla_fifo import mhla_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_AW:0]   count_nxt;
  logic               push;
  logic               pop;

  always_comb begin
    push_ready = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
    pop_valid  = (count_r != '0);
    pop_item   = mem_r[rd_ptr_r];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/mhla_back.sv -----
// Back end: products, loss sum, shared radix-2 divider and output register.
module mhla_back import mhla_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  back_cfg_t                  cfg,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  item_t                      pop_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [MARGIN_W-1:0]        margin,
  output logic signed [GRAD_W-1:0]   gradient,
  output logic [LOSS_W-1:0]          batch_loss,
  output logic                       last_out
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_GDIV = 6'b001000,
    S_LDIV = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t               state_r,  state_nxt;
  item_t                item_r,   item_nxt;
  logic [2*MARGIN_W-1:0] addend_r, addend_nxt;
  logic [GDIV_W-1:0]    gdiv_r,   gdiv_nxt;
  logic [SUM_W-1:0]     sum_r,    sum_nxt;
  logic [CFG_W-1:0]     rem_r,    rem_nxt;
  logic [DIV_W-1:0]     quo_r,    quo_nxt;
  logic [DIVCNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [GRAD_W-1:0]    grad_r,   grad_nxt;
  logic [LOSS_W-1:0]    loss_r,   loss_nxt;

  logic [2*MARGIN_W-1:0] sq;
  logic [MARGIN_W+CFG_W-1:0] mw;
  logic [SUM_W:0]       sum_ext;
  logic [CFG_W:0]       trial;
  logic [CFG_W:0]       diff;
  logic                 ge;
  logic [CFG_W-1:0]     rem_step;
  logic [DIV_W-1:0]     quo_step;
  logic [GDIV_W-1:0]    q;
  logic [GDIV_W-1:0]    mag;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, cfg.num};
    ge       = (trial >= {1'b0, cfg.num});
    rem_step = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
    quo_step = {quo_r[DIV_W-2:0], ge};
  end

  always_comb begin
    sq      = (2*MARGIN_W)'(item_r.margin) * (2*MARGIN_W)'(item_r.margin);
    mw      = (MARGIN_W+CFG_W)'(item_r.margin) * (MARGIN_W+CFG_W)'(cfg.up_weight);
    sum_ext = {1'b0, sum_r} + (SUM_W+1)'(addend_r);
    q       = quo_step[GDIV_W-1:0];
    mag     = (q > GDIV_W'(34'h0_8000_0000)) ? GDIV_W'(34'h0_8000_0000) : q;
  end

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    addend_nxt = addend_r;
    gdiv_nxt   = gdiv_r;
    sum_nxt    = sum_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    grad_nxt   = grad_r;
    loss_nxt   = loss_r;
    pop_ready  = (state_r == S_IDLE);
    out_valid  = (state_r == S_OUT);
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          item_nxt  = pop_item;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        addend_nxt = cfg.norm_select ? sq : (2*MARGIN_W)'(item_r.margin);
        if (cfg.norm_select) begin
          gdiv_nxt = {2'b00, mw, 1'b0};
        end else if (item_r.margin != '0) begin
          gdiv_nxt = {10'd0, cfg.up_weight, 8'd0};
        end else begin
          gdiv_nxt = '0;
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        quo_nxt   = {gdiv_r, (DIV_W-GDIV_W)'(0)};
        rem_nxt   = '0;
        cnt_nxt   = DIVCNT_W'(GDIV_W);
        state_nxt = S_GDIV;
      end
      S_GDIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DIVCNT_W'(1)) begin
          if (item_r.neg) begin
            grad_nxt = GRAD_W'(0) - mag[GRAD_W-1:0];
          end else if (q > GDIV_W'(34'h0_7FFF_FFFF)) begin
            grad_nxt = 32'h7FFF_FFFF;
          end else begin
            grad_nxt = q[GRAD_W-1:0];
          end
          if (item_r.last) begin
            // L1 sum is Q8.8, scale to Q16.16 before the divide
            quo_nxt   = cfg.norm_select ? {8'd0, sum_r} : {sum_r, 8'd0};
            rem_nxt   = '0;
            cnt_nxt   = DIVCNT_W'(DIV_W);
            sum_nxt   = '0;
            state_nxt = S_LDIV;
          end else begin
            loss_nxt  = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_LDIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DIVCNT_W'(1)) begin
          loss_nxt  = (quo_step > DIV_W'(32'h7FFF_FFFF)) ? '1 : quo_step[LOSS_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    addend_r <= addend_nxt;
    gdiv_r   <= gdiv_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    grad_r   <= grad_nxt;
    loss_r   <= loss_nxt;
  end

  assign margin     = item_r.margin;
  assign gradient   = grad_r;
  assign batch_loss = loss_r;
  assign last_out   = item_r.last;

endmodule

// ----- hw/rtl/masked_hinge_loss_accumulator.sv -----
// The back end takes one beat at a time, and only when idle; its pace is set by
//   the radix-2 divider, 34 steps for the gradient plus 56 for the batch loss.
// The 2-entry queue takes new beats while a result waits on out_ready.
// Reset (rst_n low, synchronous): queue empty, loss sum 0, registers back to
//   class_mode 0, norm_select 0, sample_count 1, upstream weight 256.
`include "assert_macros.svh"

module masked_hinge_loss_accumulator import mhla_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  // element input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic signed [1:0]         in_label_sign,
  input  logic                      in_mask_bit,
  input  logic [CLASS_W-1:0]        in_class_label,
  input  logic [CLASS_W-1:0]        in_element_index,
  input  logic                      in_last,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [MARGIN_W-1:0]       out_margin,
  output logic signed [GRAD_W-1:0]  out_gradient,
  output logic [LOSS_W-1:0]         out_batch_loss,
  output logic                      out_last_out
);

  // Configuration registers. Writes land any time cfg_valid is high; the
  // user must see that it only writes while the block is drained; the block does not enforce it.
  logic             class_mode_r,    class_mode_nxt;
  logic             norm_select_r,   norm_select_nxt;
  logic [CFG_W-1:0] sample_count_r,  sample_count_nxt;
  logic [CFG_W-1:0] up_weight_r,     up_weight_nxt;

  back_cfg_t bcfg;
  item_t     front_item;
  item_t     q_item;
  logic      q_valid;
  logic      q_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    class_mode_nxt   = class_mode_r;
    norm_select_nxt  = norm_select_r;
    sample_count_nxt = sample_count_r;
    up_weight_nxt    = up_weight_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_CLASS_MODE:   class_mode_nxt   = cfg_data[0];
        REG_NORM_SELECT:  norm_select_nxt  = cfg_data[0];
        REG_SAMPLE_COUNT: sample_count_nxt = cfg_data;
        REG_LOSS_WEIGHT:  up_weight_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_mode_r   <= 1'b0;
      norm_select_r  <= 1'b0;
      sample_count_r <= CFG_W'(1);
      up_weight_r    <= CFG_W'(256);
    end else begin
      class_mode_r   <= class_mode_nxt;
      norm_select_r  <= norm_select_nxt;
      sample_count_r <= sample_count_nxt;
      up_weight_r    <= up_weight_nxt;
    end
  end

  // A sample count of zero divides as one.
  always_comb begin
    bcfg.norm_select = norm_select_r;
    bcfg.num         = (sample_count_r == '0) ? CFG_W'(1) : sample_count_r;
    bcfg.up_weight   = up_weight_r;
  end

  // Front: decode label / class hit, clip the margin, note its sign.
  mhla_front u_front (
    .class_mode    (class_mode_r),
    .score         (in_score),
    .label_sign    (in_label_sign),
    .mask_bit      (in_mask_bit),
    .class_label   (in_class_label),
    .element_index (in_element_index),
    .last          (in_last),
    .item          (front_item)
  );

  // Queue decouples intake from the multi-cycle back end.
  mhla_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back: square / weight products, saturating loss sum, divides, output hold.
  mhla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (bcfg),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .margin     (out_margin),
    .gradient   (out_gradient),
    .batch_loss (out_batch_loss),
    .last_out   (out_last_out)
  );

  // Batch loss is only nonzero on the closing beat of a batch.
  `ASSERT_IMPLIES(a_loss_only_last, out_valid && !out_last_out, out_batch_loss == '0, "batch loss without last")
  // A zero margin can carry no gradient.
  `ASSERT_IMPLIES(a_zero_margin_grad, out_valid && (out_margin == '0), out_gradient == '0, "gradient on zero margin")
  // A taken result beat is never followed by another result beat back to back.
  `ASSERT_NEXT(a_result_gap, out_valid && out_ready, !out_valid, "back-to-back result beats")

endmodule

// ----- tb/hinge_loss_monitor.sv -----
// Scoreboard for the hinge loss accumulator: predicts each result beat and compares it.
module hinge_loss_monitor import mhla_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic signed [1:0]         in_label_sign,
  input  logic                      in_mask_bit,
  input  logic [CLASS_W-1:0]        in_class_label,
  input  logic [CLASS_W-1:0]        in_element_index,
  input  logic                      in_last,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [MARGIN_W-1:0]       out_margin,
  input  logic signed [GRAD_W-1:0]  out_gradient,
  input  logic [LOSS_W-1:0]         out_batch_loss,
  input  logic                      out_last_out,
  output int unsigned               n_fail,
  output int unsigned               n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MARGIN_MAX = (longint'(1) << MARGIN_W) - 1;
  localparam logic [SUM_W-1:0] SUM_CAP = '1;
  localparam logic [63:0] GRAD_POS_CAP = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] GRAD_NEG_CAP = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LOSS_CAP     = 64'h0000_0000_7FFF_FFFF;

  typedef struct packed {
    logic [MARGIN_W-1:0] margin;
    logic [GRAD_W-1:0]   gradient;
    logic [LOSS_W-1:0]   batch_loss;
    logic                last_out;
  } hinge_res_t;

  // shadow of the register file and the running loss sum
  logic             mode_multi;
  logic             norm_l2;
  logic [CFG_W-1:0] batch_num;
  logic [CFG_W-1:0] weight_q88;
  logic [SUM_W-1:0] acc_sum;

  hinge_res_t  hinge_due[$];
  int unsigned mismatch_cnt = 0;

  function automatic longint clip_q88(input longint v);
    if (v < 0) return 0;
    if (v > MARGIN_MAX) return MARGIN_MAX;
    return v;
  endfunction

  // margin, gradient and batch loss of one element; advances acc_sum
  function automatic hinge_res_t hinge_eval(
    input logic signed [SCORE_W-1:0] score,
    input logic signed [1:0]         label_sign,
    input logic                      mask_bit,
    input logic [CLASS_W-1:0]        class_label,
    input logic [CLASS_W-1:0]        element_index,
    input logic                      last
  );
    hinge_res_t  res;
    longint      sc, lb, mg, smg;
    logic [63:0] div, mag, total, loss;
    logic        hit;
    sc  = score;
    lb  = label_sign;
    div = (batch_num == '0) ? 64'd1 : 64'(batch_num);
    if (mode_multi) begin
      hit = (class_label < MAX_CLASSES) && (element_index == class_label);
      mg  = clip_q88(hit ? ONE_Q88 - sc : ONE_Q88 + sc);
      smg = hit ? -mg : mg;
    end else if (mask_bit && (lb == 1 || lb == -1)) begin
      mg  = clip_q88(ONE_Q88 - lb * sc);
      smg = -lb * mg;
    end else begin
      mg  = 0;
      smg = 0;
    end

    if (norm_l2) begin
      mag   = 64'(smg < 0 ? -smg : smg) * 64'd2 * 64'(weight_q88) / div;
      total = 64'(acc_sum) + 64'(mg) * 64'(mg);
    end else begin
      mag   = (smg == 0) ? 64'd0 : (64'(weight_q88) << 8) / div;
      total = 64'(acc_sum) + 64'(mg);
    end
    acc_sum = (total > 64'(SUM_CAP)) ? SUM_CAP : total[SUM_W-1:0];

    if (smg < 0) begin
      if (mag > GRAD_NEG_CAP) mag = GRAD_NEG_CAP;
      mag = -mag;
    end else if (mag > GRAD_POS_CAP) begin
      mag = GRAD_POS_CAP;
    end

    loss = 64'd0;
    if (last) begin
      loss = norm_l2 ? 64'(acc_sum) / div : (64'(acc_sum) << 8) / div;
      if (loss > LOSS_CAP) loss = LOSS_CAP;
      acc_sum = '0;
    end

    res.margin     = MARGIN_W'(mg);
    res.gradient   = mag[GRAD_W-1:0];
    res.batch_loss = loss[LOSS_W-1:0];
    res.last_out   = last;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    hinge_res_t want;
    if (!rst_n) begin
      mode_multi = 1'b0;
      norm_l2    = 1'b0;
      batch_num  = 16'd1;
      weight_q88 = 16'd256;
      acc_sum    = '0;
      hinge_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_CLASS_MODE:   mode_multi = cfg_data[0];
          REG_NORM_SELECT:  norm_l2    = cfg_data[0];
          REG_SAMPLE_COUNT: batch_num  = cfg_data;
          REG_LOSS_WEIGHT:  weight_q88 = cfg_data;
          default: ;
        endcase
      end
      // result side first: a beat leaving now belongs to an older element
      if (out_valid && out_ready) begin
        if (hinge_due.size() == 0) begin
          $error("result beat with nothing outstanding: margin %0d gradient %0d",
                 out_margin, out_gradient);
          mismatch_cnt++;
        end else begin
          want = hinge_due.pop_front();
          if (out_margin !== want.margin) begin
            $error("margin: expected %0d, actual %0d", want.margin, out_margin);
            mismatch_cnt++;
          end
          if (out_gradient !== want.gradient) begin
            $error("gradient: expected %0d, actual %0d",
                   $signed(want.gradient), out_gradient);
            mismatch_cnt++;
          end
          if (out_batch_loss !== want.batch_loss) begin
            $error("batch_loss: expected %0d, actual %0d", want.batch_loss, out_batch_loss);
            mismatch_cnt++;
          end
          if (out_last_out !== want.last_out) begin
            $error("last_out: expected %0d, actual %0d", want.last_out, out_last_out);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready)
        hinge_due.push_back(hinge_eval(in_score, in_label_sign, in_mask_bit,
                                       in_class_label, in_element_index, in_last));
    end
    n_fail    <= mismatch_cnt;
    n_pending <= hinge_due.size();
  end

endmodule

// ----- tb/tb_masked_hinge_loss_accumulator.sv -----
// Top of the hinge loss accumulator testbench: clock, reset, stimulus, watchdog and verdict.
module tb_masked_hinge_loss_accumulator;
  import mhla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest quiet stretch in a correct run: the longest result-side stall plus
  // the latency of a beat marked last. The limit leaves ample margin over that.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TOTAL_ELEMS    = 575;  // directed part plus ~550 random
  localparam int unsigned DRAIN_CYCLES   = 120;  // covers the latency of a beat marked last

  localparam logic signed [1:0] LBL_POS  = 2'sb01;
  localparam logic signed [1:0] LBL_NEG  = 2'sb11;
  localparam logic signed [1:0] LBL_NONE = 2'sb00;
  localparam logic signed [1:0] LBL_BAD  = 2'sb10;  // -2, must act like "ignore"

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data  = '0;

  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic signed [SCORE_W-1:0] in_score         = '0;
  logic signed [1:0]         in_label_sign    = '0;
  logic                      in_mask_bit      = 1'b0;
  logic [CLASS_W-1:0]        in_class_label   = '0;
  logic [CLASS_W-1:0]        in_element_index = '0;
  logic                      in_last          = 1'b0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [MARGIN_W-1:0]       out_margin;
  logic signed [GRAD_W-1:0]  out_gradient;
  logic [LOSS_W-1:0]         out_batch_loss;
  logic                      out_last_out;

  int unsigned n_fail, n_pending;

  // handshake seen at the last rising edge, read back at the falling edge
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;

  logic        no_idle    = 1'b0;  // burst mode: neither side inserts gaps
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned elems_sent = 0;

  always #4ns clk = ~clk;

  masked_hinge_loss_accumulator u_top (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_score, .in_label_sign, .in_mask_bit,
    .in_class_label, .in_element_index, .in_last,
    .out_valid, .out_ready, .out_margin, .out_gradient, .out_batch_loss, .out_last_out
  );

  hinge_loss_monitor u_check (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_score, .in_label_sign, .in_mask_bit,
    .in_class_label, .in_element_index, .in_last,
    .out_valid, .out_ready, .out_margin, .out_gradient, .out_batch_loss, .out_last_out,
    .n_fail, .n_pending
  );

  always @(posedge clk) begin
    in_taken  <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stall length: mostly short, now and then a long one.
  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(100, 300);
  endfunction

  // Result side back-pressure, started at random cycles so it lands on every
  // phase of the divider's work. Burst mode starts no new stall.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (rst_n && !no_idle && $urandom_range(99) < 12)
        stall_left <= stall_len();
    end
  end

  // Scores: often near the hinge point so margins are small,
  // plus full-range values and the rails.
  function automatic logic signed [SCORE_W-1:0] rand_score();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return SCORE_W'(int'($urandom_range(1023)) - 512);
    if (r < 80) return SCORE_W'($urandom);
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sd256;
      3:       return -16'sd256;
      default: return '0;
    endcase
  endfunction

  // One element beat. Called at a falling edge, returns at a falling edge.
  task automatic push_elem(input logic signed [SCORE_W-1:0] sc,
                           input logic signed [1:0] lab, input logic mask,
                           input logic [CLASS_W-1:0] cls, input logic [CLASS_W-1:0] elem,
                           input logic lst);
    int unsigned gap;
    in_valid         <= 1'b1;
    in_score         <= sc;
    in_label_sign    <= lab;
    in_mask_bit      <= mask;
    in_class_label   <= cls;
    in_element_index <= elem;
    in_last          <= lst;
    do @(negedge clk); while (!in_taken);
    elems_sent++;
    gap = (no_idle || $urandom_range(99) < 55) ? 0 : stall_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result beat has drained.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
  endtask

  // Back-to-back writes of all four registers; block must be idle.
  task automatic program_regs(input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] norm,
                              input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] weight);
    reg_idx_t         idx [4];
    logic [CFG_W-1:0] val [4];
    idx = '{REG_CLASS_MODE, REG_NORM_SELECT, REG_SAMPLE_COUNT, REG_LOSS_WEIGHT};
    val = '{mode, norm, count, weight};
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(negedge clk); while (!cfg_taken);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 16'd1;
    if (r < 20) return 16'd0;  // treated as 1 by the block
    if (r < 30) return 16'hFFFF;
    if (r < 75) return CFG_W'($urandom_range(1, 16));
    return CFG_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 16'd0;
    if (r < 25) return 16'hFFFF;
    if (r < 45) return 16'd256;
    return CFG_W'($urandom);
  endfunction

  // One batch. Multiclass samples walk element_index through a window that
  // contains (usually) the true class; binary elements carry mostly valid
  // labels with the mask set. About one beat in ten is pure noise.
  task automatic run_batch(input int unsigned len, input logic multi);
    logic [CLASS_W-1:0] base, cls;
    logic signed [1:0]  lab;
    logic               mask, lst;
    base = CLASS_W'($urandom_range(0, 1024 - len));
    cls  = ($urandom_range(9) == 0) ? CLASS_W'($urandom)
                                    : base + CLASS_W'($urandom_range(len - 1));
    for (int unsigned k = 0; k < len; k++) begin
      lst = (k == len - 1);
      if ($urandom_range(9) == 0) begin
        push_elem(SCORE_W'($urandom), 2'($urandom), 1'($urandom), CLASS_W'($urandom),
                  CLASS_W'($urandom), lst || ($urandom_range(19) == 0));
      end else if (multi) begin
        push_elem(rand_score(), 2'($urandom), 1'($urandom), cls, base + CLASS_W'(k), lst);
      end else begin
        lab  = ($urandom_range(99) < 85) ? (($urandom_range(1) != 0) ? LBL_POS : LBL_NEG)
                                         : 2'($urandom);
        mask = ($urandom_range(9) != 0);
        push_elem(rand_score(), lab, mask, CLASS_W'($urandom), CLASS_W'($urandom), lst);
      end
      // occasional full drain in the middle of a batch
      if (!lst && $urandom_range(49) == 0) settle();
    end
  endtask

  initial begin
    logic multi;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: binary, L1, one sample, unit weight.
    push_elem(16'sd0,     LBL_POS,  1'b1, '0, '0, 1'b0);
    push_elem(16'sh7FFF,  LBL_NEG,  1'b1, '0, '0, 1'b0);  // margin rails high
    push_elem(16'sh8000,  LBL_POS,  1'b1, '0, '0, 1'b0);  // margin rails high
    push_elem(16'sd300,   LBL_POS,  1'b1, '0, '0, 1'b0);  // clipped to zero
    push_elem(16'sd100,   LBL_NONE, 1'b1, '0, '0, 1'b0);  // label ignore
    push_elem(16'sd100,   LBL_BAD,  1'b1, '0, '0, 1'b0);  // -2 acts as ignore
    push_elem(-16'sd100,  LBL_NEG,  1'b0, '0, '0, 1'b0);  // masked off
    settle();                                             // drain with the batch open
    push_elem(16'sd256,   LBL_NEG,  1'b1, '1, '1, 1'b1);

    // Binary L2, zero sample count, full weight: gradient saturates both ways,
    // then the batch loss lands just below its cap.
    settle();
    program_regs(16'd0, 16'd1, 16'd0, 16'hFFFF);
    push_elem(16'sh8000,  LBL_POS,  1'b1, '0, '0, 1'b0);
    push_elem(16'sh7FFF,  LBL_NEG,  1'b1, '0, '0, 1'b0);
    push_elem(16'sd0,     LBL_POS,  1'b1, '0, '0, 1'b1);

    // Multiclass L1, largest sample count, zero weight.
    settle();
    program_regs(16'd1, 16'd0, 16'hFFFF, 16'd0);
    push_elem(16'sd0,     LBL_NONE, 1'b0, 10'd5,    10'd5,    1'b0);  // true class
    push_elem(-16'sd300,  LBL_NONE, 1'b0, 10'd5,    10'd6,    1'b0);  // clipped
    push_elem(16'sh8000,  LBL_POS,  1'b1, 10'd1023, 10'd1023, 1'b0);  // rails high
    push_elem(16'sh7FFF,  LBL_NEG,  1'b1, 10'd0,    10'd1023, 1'b0);  // rails high
    push_elem(-16'sd256,  LBL_NONE, 1'b0, 10'd1023, 10'd0,    1'b1);

    // Multiclass L2, three samples, full weight.
    settle();
    program_regs(16'd1, 16'd1, 16'd3, 16'hFFFF);
    push_elem(-16'sd100,  LBL_NONE, 1'b0, 10'd0, 10'd0, 1'b0);
    push_elem(16'sd100,   LBL_NONE, 1'b0, 10'd0, 10'd1, 1'b0);
    push_elem(16'sh8000,  LBL_NONE, 1'b0, 10'd0, 10'd2, 1'b1);

    // Random phases: drain, reprogram, then a few batches.
    while (elems_sent < TOTAL_ELEMS) begin
      settle();
      no_idle = ($urandom_range(3) == 0);
      multi   = 1'($urandom);
      program_regs({CFG_W'($urandom) & 16'hFFFE} | CFG_W'(multi), CFG_W'($urandom),
                   pick_count(), pick_weight());
      repeat ($urandom_range(1, 4))
        run_batch(($urandom_range(4) == 0) ? $urandom_range(13, 40)
                                           : $urandom_range(1, 12), multi);
    end

    settle();
    no_idle = 1'b1;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
